### rtl/tcs_pkg.sv
// tcs_pkg: types, codes and result builders for the TCP connection state table.
// Used by tcp_connection_state_table; depends on nothing.
`timescale 1ns / 1ps

package tcs_pkg;

    localparam logic [2:0] OP_SEGMENT    = 3'd0;
    localparam logic [2:0] OP_LISTEN     = 3'd1;
    localparam logic [2:0] OP_CONNECT    = 3'd2;
    localparam logic [2:0] OP_ACCEPT     = 3'd3;
    localparam logic [2:0] OP_DISCONNECT = 3'd4;
    localparam logic [2:0] OP_RELEASE    = 3'd5;
    localparam logic [2:0] OP_SEND       = 3'd6;
    localparam logic [2:0] OP_UNKNOWN    = 3'd7;

    localparam logic [5:0] FL_FIN = 6'd1;
    localparam logic [5:0] FL_SYN = 6'd2;
    localparam logic [5:0] FL_PSH = 6'd8;
    localparam logic [5:0] FL_ACK = 6'd16;

    localparam logic [3:0] ST_EMPTY      = 4'd0;
    localparam logic [3:0] ST_LISTEN     = 4'd1;
    localparam logic [3:0] ST_SYN_SENT   = 4'd2;
    localparam logic [3:0] ST_SYN_RCVD   = 4'd3;
    localparam logic [3:0] ST_ESTAB      = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT1  = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT2  = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT = 4'd7;
    localparam logic [3:0] ST_CLOSED     = 4'd8;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;
    localparam logic [1:0] KIND_NOTIFY  = 2'd3;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_BUSY   = 2'd1;
    localparam logic [1:0] STS_STATE  = 2'd2;
    localparam logic [1:0] STS_RANGE  = 2'd3;

    localparam logic REG_LOCAL_IP   = 1'b0;
    localparam logic REG_FIRST_PORT = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] peer_addr;
        logic [31:0] seq_in;
        logic [5:0]  flags_in;
        logic [15:0] data_len;
        logic [15:0] owner_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [6:0]  port_out;
        logic [15:0] peer_port_out;
        logic [31:0] peer_ip_out;
        logic [31:0] seq_out;
        logic [31:0] ack_out;
        logic [5:0]  flags_out;
        logic [15:0] length_out;
        logic [15:0] notify_owner;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] peer_port;
        logic [31:0] peer_ip;
        logic [15:0] owner;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_CHECK,
        S_EXEC,
        S_OUT0,
        S_OUT1
    } fsm_t;

    function automatic out_item_t status_res(logic [1:0] sts, logic [6:0] port);
        out_item_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = sts;
        r.port_out = port;
        return r;
    endfunction

    function automatic out_item_t seg_res(logic [6:0] port, entry_t e, logic [5:0] flags,
                                          logic [15:0] len);
        out_item_t r;
        r = '0;
        r.kind = KIND_SEGMENT;
        r.port_out = port;
        r.peer_port_out = e.peer_port;
        r.peer_ip_out = e.peer_ip;
        r.seq_out = e.seq;
        r.ack_out = e.ack;
        r.flags_out = flags;
        r.length_out = len;
        return r;
    endfunction

endpackage

### rtl/tcs_ram.sv
// tcs_ram: single write port, single read port memory with registered read data.
// Generic; no package dependency.
`timescale 1ns / 1ps

module tcs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/tcp_connection_state_table.sv
// tcp_connection_state_table: per-port TCP connection state kept in two memories.
// Depends on tcs_pkg and tcs_ram.
// Port commands and segments pass through dispatch (memory read), execute and, per
// result, output states; connect also steps through search and check for each table
// entry scanned from first_port_reg. One item at a time: no new item is taken until
// the results of the last, if any, have been taken, including any result stall.
// Reset: control clears at once, then a clearing pass empties all NUM_SOCKETS entries
// of the state memory while no item is taken.
`timescale 1ns / 1ps

module tcp_connection_state_table #(
    parameter int NUM_SOCKETS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  tcs_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output tcs_pkg::out_item_t result
);

    import tcs_pkg::*;

    localparam int IW = $clog2(NUM_SOCKETS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SOCKETS - 1);

    fsm_t state_reg, state_next;
    logic [31:0]   local_ip_reg;
    logic [6:0]    first_port_reg;
    in_item_t      item_reg;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    out_item_t     r0_reg, r1_reg;
    logic [1:0]    n_reg;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [3:0]    st_rd;
    logic [ENTRY_W-1:0] ent_rd;
    logic          st_we;
    logic [IW-1:0] st_waddr;
    logic [3:0]    st_wdata;

    logic          x_st_we, x_d_we;
    logic [3:0]    x_st;
    entry_t        x_ent;
    out_item_t     x_r0, x_r1;
    logic [1:0]    x_n;
    logic [IW-1:0] p;

    logic lport_oor, fdp_oor;

    assign lport_oor = {16'd0, item_reg.local_port} >= 32'(NUM_SOCKETS);
    assign fdp_oor   = {25'd0, first_port_reg} >= 32'(NUM_SOCKETS);
    assign p = (item_reg.opcode == OP_CONNECT) ? idx_reg : IW'(item_reg.local_port);

    tcs_ram #(.WIDTH(4), .DEPTH(NUM_SOCKETS)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (st_rd)
    );

    tcs_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SOCKETS)) u_entry_ram (
        .clk   (clk),
        .we    (x_d_we && state_reg == S_EXEC),
        .waddr (p),
        .wdata (x_ent),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ent_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                found_next = 1'b0;
                idx_next = IW'({25'd0, first_port_reg});
                if (item_reg.opcode == OP_CONNECT && !fdp_oor)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_SEARCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (st_rd == ST_EMPTY)
                begin
                    found_next = 1'b1;
                    state_next = S_EXEC;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_EXEC:
            begin
                state_next = (x_n == 2'd0) ? S_IDLE : S_OUT0;
            end
            S_OUT0:
            begin
                if (!result_stall)
                begin
                    state_next = (n_reg == 2'd2) ? S_OUT1 : S_IDLE;
                end
            end
            S_OUT1:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall = (state_reg != S_IDLE);
        result_valid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
        rd_en = (state_reg == S_DISPATCH) || (state_reg == S_SEARCH);
        rd_addr = (state_reg == S_SEARCH) ? idx_reg : IW'(item_reg.local_port);
        st_we = 1'b0;
        st_waddr = p;
        st_wdata = x_st;
        if (state_reg == S_CLEAR)
        begin
            st_we = 1'b1;
            st_waddr = clr_reg;
            st_wdata = ST_EMPTY;
        end
        else if (state_reg == S_EXEC)
        begin
            st_we = x_st_we;
        end
        result = (state_reg == S_OUT1) ? r1_reg : r0_reg;
        result.last = (state_reg == S_OUT1) || (n_reg == 2'd1);
    end

    always_comb
    begin
        entry_t     e;
        logic [3:0] st;
        logic [6:0] port7;
        logic [5:0] f;
        logic       deliver;
        e = ent_rd;
        st = st_rd;
        port7 = 7'(p);
        f = item_reg.flags_in & (FL_SYN | FL_ACK | FL_FIN);
        deliver = 1'b0;
        x_st_we = 1'b0;
        x_d_we = 1'b0;
        x_st = st;
        x_ent = e;
        x_r0 = '0;
        x_r1 = '0;
        x_n = 2'd1;
        priority if (item_reg.opcode == OP_CONNECT)
        begin
            if (!found_reg)
            begin
                x_r0 = status_res(STS_BUSY, 7'd0);
            end
            else
            begin
                x_st_we = 1'b1;
                x_d_we = 1'b1;
                x_st = ST_SYN_SENT;
                x_ent = '0;
                x_ent.peer_port = item_reg.remote_port;
                x_ent.peer_ip = item_reg.peer_addr;
                x_r0 = seg_res(port7, x_ent, FL_SYN, 16'd0);
            end
        end
        else if (item_reg.opcode == OP_UNKNOWN)
        begin
            x_r0 = status_res(STS_STATE, 7'd0);
        end
        else if (lport_oor)
        begin
            x_r0 = status_res(STS_RANGE, item_reg.local_port[6:0]);
        end
        else if (item_reg.opcode == OP_LISTEN)
        begin
            if (st != ST_EMPTY)
            begin
                x_r0 = status_res(STS_BUSY, port7);
            end
            else
            begin
                x_st_we = 1'b1;
                x_d_we = 1'b1;
                x_st = ST_LISTEN;
                x_ent = '0;
                x_r0 = status_res(STS_OK, port7);
            end
        end
        else if (item_reg.opcode == OP_ACCEPT)
        begin
            if (st != ST_LISTEN)
            begin
                x_r0 = status_res(STS_STATE, port7);
            end
            else
            begin
                x_d_we = 1'b1;
                x_ent.owner = item_reg.owner_id;
                x_r0 = status_res(STS_OK, port7);
            end
        end
        else if (item_reg.opcode != OP_SEGMENT)
        begin
            if (st == ST_EMPTY)
            begin
                x_r0 = status_res(STS_STATE, port7);
            end
            else if (item_reg.opcode == OP_DISCONNECT)
            begin
                x_st_we = 1'b1;
                x_d_we = 1'b1;
                x_st = ST_FIN_WAIT1;
                x_r0 = seg_res(port7, e, FL_FIN | FL_ACK, 16'd0);
                x_ent.seq = e.seq + 32'd1;
            end
            else if (item_reg.opcode == OP_RELEASE)
            begin
                x_st_we = 1'b1;
                x_st = ST_EMPTY;
                x_r0 = seg_res(port7, e, FL_FIN | FL_ACK, 16'd0);
            end
            else
            begin
                x_d_we = 1'b1;
                x_r0 = seg_res(port7, e, FL_PSH | FL_ACK, item_reg.data_len);
                x_ent.seq = e.seq + {16'd0, item_reg.data_len};
            end
        end
        else if (st == ST_EMPTY)
        begin
            x_n = 2'd0;
        end
        else
        begin
            x_n = 2'd0;
            priority if (f == FL_SYN)
            begin
                if (st == ST_LISTEN)
                begin
                    x_st_we = 1'b1;
                    x_d_we = 1'b1;
                    x_st = ST_SYN_RCVD;
                    x_ent.peer_port = item_reg.remote_port;
                    x_ent.peer_ip = item_reg.peer_addr;
                    x_ent.ack = item_reg.seq_in + 32'd1;
                    x_ent.seq = 32'd0;
                    x_r0 = seg_res(port7, x_ent, FL_SYN | FL_ACK, 16'd0);
                    x_ent.seq = 32'd1;
                    x_n = 2'd1;
                end
            end
            else if (f == (FL_SYN | FL_ACK))
            begin
                if (st == ST_SYN_SENT)
                begin
                    x_st_we = 1'b1;
                    x_d_we = 1'b1;
                    x_st = ST_ESTAB;
                    x_ent.seq = e.seq + 32'd1;
                    x_ent.ack = item_reg.seq_in + 32'd1;
                    x_r0 = seg_res(port7, x_ent, FL_ACK, 16'd0);
                    x_n = 2'd1;
                end
            end
            else if (f == FL_FIN || f == (FL_FIN | FL_ACK))
            begin
                priority if (st == ST_ESTAB)
                begin
                    x_st_we = 1'b1;
                    x_d_we = 1'b1;
                    x_st = ST_CLOSE_WAIT;
                    x_ent.ack = e.ack + 32'd1;
                    x_r0 = seg_res(port7, x_ent, FL_ACK, 16'd0);
                    x_r1 = seg_res(port7, x_ent, FL_FIN | FL_ACK, 16'd0);
                    x_n = 2'd2;
                end
                else if (st == ST_CLOSE_WAIT)
                begin
                    x_st_we = 1'b1;
                    x_st = ST_CLOSED;
                end
                else if (st == ST_FIN_WAIT1 || st == ST_FIN_WAIT2)
                begin
                    x_st_we = 1'b1;
                    x_d_we = 1'b1;
                    x_st = ST_CLOSED;
                    x_ent.ack = e.ack + 32'd1;
                    x_r0 = seg_res(port7, x_ent, FL_ACK, 16'd0);
                    x_n = 2'd1;
                end
                else
                begin
                    x_n = 2'd0;
                end
            end
            else if (f == FL_ACK)
            begin
                priority if (st == ST_SYN_RCVD)
                begin
                    x_st_we = 1'b1;
                    x_st = ST_ESTAB;
                    x_r0 = '0;
                    x_r0.kind = KIND_NOTIFY;
                    x_r0.port_out = port7;
                    x_r0.peer_port_out = item_reg.remote_port;
                    x_r0.peer_ip_out = e.peer_ip;
                    x_r0.notify_owner = e.owner;
                    x_n = 2'd1;
                end
                else if (st == ST_FIN_WAIT1)
                begin
                    x_st_we = 1'b1;
                    x_st = ST_FIN_WAIT2;
                end
                else if (st == ST_CLOSE_WAIT)
                begin
                    x_st_we = 1'b1;
                    x_st = ST_CLOSED;
                end
                else
                begin
                    deliver = 1'b1;
                end
            end
            else
            begin
                deliver = 1'b1;
            end
            if (deliver && item_reg.seq_in == e.ack)
            begin
                x_d_we = 1'b1;
                x_r0 = '0;
                x_r0.kind = KIND_DELIVER;
                x_r0.port_out = port7;
                x_r0.peer_port_out = e.peer_port;
                x_r0.peer_ip_out = e.peer_ip;
                x_r0.length_out = item_reg.data_len;
                x_ent.ack = e.ack + {16'd0, item_reg.data_len};
                x_r1 = seg_res(port7, x_ent, FL_ACK, 16'd0);
                x_n = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            n_reg <= 2'd0;
            local_ip_reg <= 32'd0;
            first_port_reg <= 7'd12;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            idx_reg <= idx_next;
            found_reg <= found_next;
            if (state_reg == S_EXEC)
            begin
                n_reg <= x_n;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOCAL_IP:   local_ip_reg <= cfg_data;
                    REG_FIRST_PORT: first_port_reg <= cfg_data[6:0];
                    default:        local_ip_reg <= local_ip_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (state_reg == S_EXEC)
        begin
            r0_reg <= x_r0;
            r1_reg <= x_r1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item taken while previous one in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (n_reg != 2'd0))
        else $error("result shown with no result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(st_we && rd_en))
        else $error("state memory read and write overlap");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !result_valid)
        else $error("result during clearing pass");

endmodule
